FILE: rtl/core/utf8v_pkg.sv
package utf8v_pkg;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int CODE_W  = 4;
   localparam int COUNT_W = 9;
   localparam int CP_W    = 21;
   localparam int PEND_W  = 2;
   localparam int INDEX_W = 2;

   // Byte counter ceiling; above every length limit
   localparam logic [COUNT_W-1:0] COUNT_CEILING = 9'd256;

   // Register reset values
   localparam logic [BYTE_W-1:0] MAX_NAME_RESET   = 8'd32;
   localparam logic [BYTE_W-1:0] MIN_SECRET_RESET = 8'd8;
   localparam logic [BYTE_W-1:0] MAX_SECRET_RESET = 8'd63;

   // Character bounds
   localparam logic [BYTE_W-1:0] PRINT_LOW  = 8'h20;
   localparam logic [BYTE_W-1:0] PRINT_HIGH = 8'h7e;
   localparam logic [BYTE_W-1:0] DEL_BYTE   = 8'h7f;

   // Code point bounds
   localparam logic [CP_W-1:0] MIN_TWO_BYTE   = 21'h000080;
   localparam logic [CP_W-1:0] MIN_THREE_BYTE = 21'h000800;
   localparam logic [CP_W-1:0] MIN_FOUR_BYTE  = 21'h010000;
   localparam logic [CP_W-1:0] MAX_CODE_POINT = 21'h10ffff;
   localparam logic [CP_W-1:0] SURROGATE_LOW  = 21'h00d800;
   localparam logic [CP_W-1:0] SURROGATE_HIGH = 21'h00dfff;

   typedef enum logic [CODE_W-1:0] {
      ERR_NONE      = 4'd0,
      ERR_EMPTY     = 4'd1,
      ERR_TOO_LONG  = 4'd2,
      ERR_TOO_SHORT = 4'd3,
      ERR_CONTROL   = 4'd4,
      ERR_BAD_LEAD  = 4'd5,
      ERR_BAD_CONT  = 4'd6,
      ERR_TRUNCATED = 4'd7,
      ERR_OVERLONG  = 4'd8,
      ERR_SURROGATE = 4'd9,
      ERR_RANGE     = 4'd10
   } error_code_type;

   typedef enum logic {
      MODE_NAME   = 1'b0,
      MODE_SECRET = 1'b1
   } check_mode_type;

   typedef enum logic [INDEX_W-1:0] {
      CSR_CHECK_MODE  = 2'd0,
      CSR_MAX_NAME    = 2'd1,
      CSR_MIN_SECRET  = 2'd2,
      CSR_MAX_SECRET  = 2'd3
   } csr_index_type;

endpackage

FILE: rtl/core/utf8v_req_if.sv
interface utf8v_req_if;
   logic                          valid;
   logic                          ready;
   logic [utf8v_pkg::BYTE_W-1:0]  data_byte;
   logic                          is_last;
   logic                          is_empty;

   modport source (output valid, output data_byte, output is_last, output is_empty,
                   input ready);
   modport sink   (input valid, input data_byte, input is_last, input is_empty,
                   output ready);
endinterface

FILE: rtl/core/utf8v_rsp_if.sv
interface utf8v_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          valid_res;
   logic [utf8v_pkg::CODE_W-1:0]  error_code;

   modport source (output valid, output valid_res, output error_code, input ready);
   modport sink   (input valid, input valid_res, input error_code, output ready);
endinterface

FILE: rtl/core/utf8_string_validator_unit.sv
// A verdict is registered: the last word of a string passes the input register and then the verdict register.
// Throughput: one word per cycle, but a last or empty word waits while a verdict is not yet taken;
// each word is decoded by combinational logic between the input register and the verdict register.
// Reset (synchronous, active high): clears the string state, the pipeline valids
// and restores the registers to mode name, name limit 32, secret limits 8 and 63.
module utf8_string_validator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   utf8v_req_if.sink                            req_chan,
   utf8v_rsp_if.source                          rsp_chan,
   input  logic                                 csr_we,
   input  logic [utf8v_pkg::INDEX_W-1:0]        csr_index,
   input  logic [utf8v_pkg::BYTE_W-1:0]         csr_wdata
);

   // Configuration registers
   utf8v_pkg::check_mode_type          mode_ff;
   logic [utf8v_pkg::BYTE_W-1:0]       max_name_ff;
   logic [utf8v_pkg::BYTE_W-1:0]       min_secret_ff;
   logic [utf8v_pkg::BYTE_W-1:0]       max_secret_ff;

   // Input register
   logic                               s1_valid_ff;
   logic [utf8v_pkg::BYTE_W-1:0]       s1_byte_ff;
   logic                               s1_last_ff;
   logic                               s1_empty_ff;

   // String state
   logic [utf8v_pkg::PEND_W-1:0]       pend_ff, pend_in;
   logic [utf8v_pkg::PEND_W-1:0]       seq_ff, seq_in;
   logic [utf8v_pkg::CP_W-1:0]         cp_ff, cp_in;
   logic [utf8v_pkg::COUNT_W-1:0]      count_ff, count_in;
   utf8v_pkg::error_code_type          fault_ff, fault_in;

   // Verdict register
   logic                               out_valid_ff;
   logic                               out_res_ff;
   utf8v_pkg::error_code_type          out_code_ff;

   logic                               has_result;
   logic                               out_free;
   logic                               s1_fire;
   logic                               req_fire;
   utf8v_pkg::error_code_type          verdict;
   logic [utf8v_pkg::CP_W-1:0]         cp_acc;
   logic [utf8v_pkg::BYTE_W-1:0]       b;

   // Handshake
   assign has_result    = s1_empty_ff | s1_last_ff;
   assign out_free      = ~out_valid_ff | rsp_chan.ready;
   assign s1_fire       = s1_valid_ff & (~has_result | out_free);
   assign req_chan.ready = ~s1_valid_ff | s1_fire;
   assign req_fire      = req_chan.valid & req_chan.ready;

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.valid_res  = out_res_ff;
   assign rsp_chan.error_code = out_code_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= utf8v_pkg::MODE_NAME;
         max_name_ff   <= utf8v_pkg::MAX_NAME_RESET;
         min_secret_ff <= utf8v_pkg::MIN_SECRET_RESET;
         max_secret_ff <= utf8v_pkg::MAX_SECRET_RESET;
      end else if (csr_we) begin
         case (utf8v_pkg::csr_index_type'(csr_index))
            utf8v_pkg::CSR_CHECK_MODE: mode_ff <= utf8v_pkg::check_mode_type'(csr_wdata[0]);
            utf8v_pkg::CSR_MAX_NAME:   max_name_ff   <= csr_wdata;
            utf8v_pkg::CSR_MIN_SECRET: min_secret_ff <= csr_wdata;
            utf8v_pkg::CSR_MAX_SECRET: max_secret_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture incoming word
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff  <= req_chan.data_byte;
         s1_last_ff  <= req_chan.is_last;
         s1_empty_ff <= req_chan.is_empty;
      end
   end

   // Decode one byte against the string state
   always_comb begin
      b        = s1_byte_ff;
      pend_in  = pend_ff;
      seq_in   = seq_ff;
      cp_in    = cp_ff;
      count_in = count_ff;
      fault_in = fault_ff;
      cp_acc   = {cp_ff[utf8v_pkg::CP_W-7:0], b[5:0]};
      if (!s1_empty_ff) begin
         if (count_ff < utf8v_pkg::COUNT_CEILING) begin
            count_in = count_ff + 9'd1;
         end
         if (fault_ff == utf8v_pkg::ERR_NONE) begin
            if (mode_ff == utf8v_pkg::MODE_SECRET) begin
               if (b < utf8v_pkg::PRINT_LOW || b > utf8v_pkg::PRINT_HIGH) begin
                  fault_in = utf8v_pkg::ERR_CONTROL;
               end
            end else if (pend_ff == '0) begin
               // lead or plain ASCII byte
               if (!b[7]) begin
                  if (b < utf8v_pkg::PRINT_LOW || b == utf8v_pkg::DEL_BYTE) begin
                     fault_in = utf8v_pkg::ERR_CONTROL;
                  end
               end else if (b[7:5] == 3'b110) begin
                  seq_in  = 2'd1;
                  pend_in = 2'd1;
                  cp_in   = {16'd0, b[4:0]};
               end else if (b[7:4] == 4'b1110) begin
                  seq_in  = 2'd2;
                  pend_in = 2'd2;
                  cp_in   = {17'd0, b[3:0]};
               end else if (b[7:3] == 5'b11110) begin
                  seq_in  = 2'd3;
                  pend_in = 2'd3;
                  cp_in   = {18'd0, b[2:0]};
               end else begin
                  fault_in = utf8v_pkg::ERR_BAD_LEAD;
               end
            end else if (b[7:6] != 2'b10) begin
               fault_in = utf8v_pkg::ERR_BAD_CONT;
            end else begin
               // continuation byte: shift in six bits, judge when complete
               cp_in   = cp_acc;
               pend_in = pend_ff - 2'd1;
               if (pend_ff == 2'd1) begin
                  if ((seq_ff == 2'd1 && cp_acc < utf8v_pkg::MIN_TWO_BYTE) ||
                      (seq_ff == 2'd2 && cp_acc < utf8v_pkg::MIN_THREE_BYTE) ||
                      (seq_ff == 2'd3 && cp_acc < utf8v_pkg::MIN_FOUR_BYTE)) begin
                     fault_in = utf8v_pkg::ERR_OVERLONG;
                  end else if (cp_acc > utf8v_pkg::MAX_CODE_POINT) begin
                     fault_in = utf8v_pkg::ERR_RANGE;
                  end else if (cp_acc >= utf8v_pkg::SURROGATE_LOW &&
                               cp_acc <= utf8v_pkg::SURROGATE_HIGH) begin
                     fault_in = utf8v_pkg::ERR_SURROGATE;
                  end
               end
            end
         end
      end
   end

   // Pick the verdict from the updated state
   always_comb begin
      verdict = utf8v_pkg::ERR_NONE;
      if (mode_ff == utf8v_pkg::MODE_NAME) begin
         if (count_in == '0) begin
            verdict = utf8v_pkg::ERR_EMPTY;
         end else if (count_in > {1'b0, max_name_ff}) begin
            verdict = utf8v_pkg::ERR_TOO_LONG;
         end else if (fault_in != utf8v_pkg::ERR_NONE) begin
            verdict = fault_in;
         end else if (pend_in != '0) begin
            verdict = utf8v_pkg::ERR_TRUNCATED;
         end
      end else if (count_in != '0) begin
         if (count_in < {1'b0, min_secret_ff}) begin
            verdict = utf8v_pkg::ERR_TOO_SHORT;
         end else if (count_in > {1'b0, max_secret_ff}) begin
            verdict = utf8v_pkg::ERR_TOO_LONG;
         end else begin
            verdict = fault_in;
         end
      end
   end

   // Advance string state; clear it after each verdict
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         seq_ff   <= '0;
         cp_ff    <= '0;
         count_ff <= '0;
         fault_ff <= utf8v_pkg::ERR_NONE;
      end else if (s1_fire) begin
         if (has_result) begin
            pend_ff  <= '0;
            seq_ff   <= '0;
            cp_ff    <= '0;
            count_ff <= '0;
            fault_ff <= utf8v_pkg::ERR_NONE;
         end else begin
            pend_ff  <= pend_in;
            seq_ff   <= seq_in;
            cp_ff    <= cp_in;
            count_ff <= count_in;
            fault_ff <= fault_in;
         end
      end
   end

   // Hold the verdict until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_fire && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && has_result) begin
         out_res_ff  <= (verdict == utf8v_pkg::ERR_NONE);
         out_code_ff <= verdict;
      end
   end

endmodule
